// ===== src/etsc_pkg.sv =====
// Shared constants and register codes of the encoder-tracked sine commutator.
package etsc_pkg;

  localparam int ANGLE_BITS_DEF = 12;
  localparam int DUTY_BITS_DEF  = 8;

  localparam int SAMPLE_W = 12;
  localparam int TORQUE_W = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  // Quarter-wave sine polynomial coefficients, Q2.30
  localparam logic [31:0] SIN_A   = 32'd1686629684;
  localparam logic [31:0] SIN_B   = 32'd693598564;
  localparam logic [31:0] SIN_C   = 32'd80710704;
  localparam logic [31:0] ONE_Q30 = 32'h4000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENC_REVERSE = 3'd0,
    REG_POLE_PAIRS  = 3'd1,
    REG_ZERO_OFFSET = 3'd2,
    REG_VOLT_LIMIT  = 3'd3,
    REG_SUPPLY      = 3'd4,
    REG_SAMPLE_RATE = 3'd5,
    REG_VEL_ALPHA   = 3'd6
  } cfg_idx_t;

endpackage

// ===== src/etsc_if.sv =====
// Channel interfaces: sample input, result output and register write port.
interface etsc_in_if;
  logic                                valid;
  logic                                ready;
  logic [etsc_pkg::SAMPLE_W-1:0]        encoder_sample;
  logic                                sample_ok;
  logic signed [etsc_pkg::TORQUE_W-1:0] torque_cmd;
  modport source(output valid, encoder_sample, sample_ok, torque_cmd, input ready);
  modport sink(input valid, encoder_sample, sample_ok, torque_cmd, output ready);
endinterface

interface etsc_out_if #(parameter int DUTY_BITS = etsc_pkg::DUTY_BITS_DEF);
  logic                 valid;
  logic                 ready;
  logic [DUTY_BITS-1:0] duty_a;
  logic [DUTY_BITS-1:0] duty_b;
  logic [DUTY_BITS-1:0] duty_c;
  logic signed [31:0]   position;
  logic signed [31:0]   speed;
  logic                 tracking_updated;
  modport source(output valid, duty_a, duty_b, duty_c, position, speed, tracking_updated,
                 input ready);
  modport sink(input valid, duty_a, duty_b, duty_c, position, speed, tracking_updated,
               output ready);
endinterface

interface etsc_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [etsc_pkg::CFG_IDX_W-1:0]  index;
  logic [etsc_pkg::CFG_DATA_W-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== src/encoder_tracked_sine_commutator.sv =====
// Top level: encoder tracking, velocity filter and three-phase sine commutation.
// One word is in flight at a time. A bit-serial shift-add multiplier forms the velocity
// filter, sine polynomial and amplitude products one multiplier bit a cycle; the angle,
// square, rate and numerator products are combinational.
// A finished word waits in the output register while the next word is taken.
// Synchronous active-low reset clears state, tracking and loads register defaults.
module encoder_tracked_sine_commutator #(
  parameter int ANGLE_BITS = etsc_pkg::ANGLE_BITS_DEF,
  parameter int DUTY_BITS  = etsc_pkg::DUTY_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  etsc_in_if.sink        in_ch,
  etsc_out_if.source     out_ch,
  etsc_cfg_if.sink       cfg_ch
);

  localparam int AB      = ANGLE_BITS;
  localparam int QB      = DUTY_BITS - 1;
  localparam int TURN    = 1 << AB;
  localparam int X2SH    = 34 - 2 * AB;
  localparam int CW      = $clog2(QB + 1);
  localparam logic [AB-1:0] QTR    = AB'(TURN / 4);
  localparam logic [AB-1:0] OFF_B  = AB'((TURN + 1) / 3);
  localparam logic [AB-1:0] OFF_C  = AB'((2 * TURN + 1) / 3);
  localparam logic [AB-2:0] QTR_X  = (AB-1)'(TURN / 4);
  localparam logic signed [AB:0] HALF_S = (AB+1)'(TURN / 2);
  localparam logic signed [AB:0] TURN_S = (AB+1)'(TURN);
  localparam logic [QB-1:0] DM1    = {QB{1'b1}};
  localparam logic [DUTY_BITS-1:0] MID = DUTY_BITS'(1 << QB);
  localparam logic [CW-1:0] LAST_STEP = CW'(QB - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_TRACK, S_DIFF, S_VMUL, S_ELEC, S_SIN, S_M1, S_M2, S_M3, S_M4, S_DIV, S_DONE
  } state_t;

  state_t state_r;

  // configuration registers
  logic           rev_r;
  logic [6:0]     pole_r;
  logic [11:0]    zo_r;
  logic [15:0]    vlim_r, vsup_r, rate_r, alpha_r;

  // input word and tracking state
  logic [AB-1:0]        raw_r;
  logic                 ok_r;
  logic signed [15:0]   tq_r;
  logic [AB-1:0]        prev_r;
  logic [31:0]          turn_r, sf_r;
  logic                 seen_r;
  logic signed [AB:0]   d_r;

  // serial multiplier, divider and lane state
  logic [63:0]          ma_r, acc_r, rem_r, dv_r;
  logic [31:0]          mb_r;
  logic [QB-1:0]        q_r;
  logic [CW-1:0]        cnt_r;
  logic [AB-1:0]        phase_r;
  logic [15+QB:0]       numdm_r;
  logic [AB-2:0]        x_r;
  logic [1:0]           quad_r;
  logic                 neg_r;
  logic [1:0]           lane_r;
  logic [DUTY_BITS-1:0] da_r, db_r, dc_r;

  // output register
  logic                 ovalid_r, oupd_r;
  logic [DUTY_BITS-1:0] oa_r, ob_r, oc_r;
  logic [31:0]          opos_r, ospd_r;

  // tracking datapath
  logic [AB-1:0]        angle_w, prev_eff;
  logic [31:0]          turn_eff;
  logic signed [AB:0]   draw_w, dwrap_w;
  logic signed [AB+17:0] dr_w;
  logic signed [63:0]   diff_w;
  logic [63:0]          vshift_w;

  assign angle_w  = rev_r ? raw_r : ({AB{1'b0}} - raw_r);
  assign prev_eff = seen_r ? prev_r : angle_w;
  assign turn_eff = seen_r ? turn_r : 32'(angle_w);
  assign draw_w   = $signed({1'b0, angle_w}) - $signed({1'b0, prev_eff});

  always_comb begin
    dwrap_w = draw_w;
    if (draw_w > HALF_S) begin
      dwrap_w = draw_w - TURN_S;
    end else if (draw_w < -HALF_S) begin
      dwrap_w = draw_w + TURN_S;
    end
  end

  assign dr_w     = d_r * $signed({1'b0, rate_r});
  assign diff_w   = 64'(dr_w) - 64'($signed(sf_r));
  assign vshift_w = 64'($signed(acc_r) >>> 16);

  // electrical angle, clamped torque and amplitude numerator
  logic [AB+6:0]        ep_w;
  logic [AB-1:0]        e_w, phase_w;
  logic signed [17:0]   vx_w, lim_w, vc_w;
  logic [17:0]          absv_w, num2_w;
  logic [15:0]          numc_w;
  logic [15+QB:0]       numdm_w;

  assign ep_w  = turn_r[AB-1:0] * pole_r;
  assign e_w   = ep_w[AB-1:0] - AB'(zo_r);
  assign vx_w  = 18'(tq_r);
  assign lim_w = $signed({2'b00, vlim_r});

  always_comb begin
    vc_w = vx_w;
    if (vx_w > lim_w) begin
      vc_w = lim_w;
    end else if (vx_w < -lim_w) begin
      vc_w = -lim_w;
    end
  end

  assign absv_w  = vc_w[17] ? 18'(-vc_w) : 18'(vc_w);
  assign num2_w  = {absv_w[16:0], 1'b0};
  assign numc_w  = (num2_w > {2'b00, vsup_r}) ? vsup_r : num2_w[15:0];
  assign phase_w = vc_w[17] ? (e_w - QTR) : (e_w + QTR);
  assign numdm_w = numc_w * DM1;

  // lane phase and quarter-wave argument
  logic [AB-1:0]        off_w, p_w;
  logic [AB-2:0]        x_w;
  logic [2*AB-3:0]      xx_w;
  logic [31:0]          x2_w;

  always_comb begin
    case (lane_r)
      2'd1:    off_w = OFF_B;
      2'd2:    off_w = OFF_C;
      default: off_w = '0;
    endcase
  end

  assign p_w  = phase_r + off_w;
  assign x_w  = p_w[AB-2] ? (QTR_X - {1'b0, p_w[AB-3:0]}) : {1'b0, p_w[AB-3:0]};
  assign xx_w = x_w * x_w;
  assign x2_w = 32'(xx_w) << X2SH;

  // polynomial terms and sine magnitude
  logic [31:0]          acc_hi, t1_w, t2_w, mag_w;
  logic [63:0]          sfull_w;
  logic                 mul_done, div_ge;
  logic [QB-1:0]        q_fin;
  logic [DUTY_BITS-1:0] term_w, duty_w;

  assign acc_hi   = acc_r[61:30];
  assign t1_w     = etsc_pkg::SIN_B - acc_hi;
  assign t2_w     = etsc_pkg::SIN_A - acc_hi;
  assign sfull_w  = acc_r >> (AB - 2);
  assign mag_w    = (sfull_w > 64'(etsc_pkg::ONE_Q30)) ? etsc_pkg::ONE_Q30 : sfull_w[31:0];
  assign mul_done = (mb_r == '0);
  assign div_ge   = (rem_r >= dv_r);
  assign q_fin    = {q_r[QB-2:0], div_ge};
  assign term_w   = (vsup_r == '0) ? '0 : DUTY_BITS'(q_fin);
  assign duty_w   = neg_r ? (MID - term_w) : (MID + term_w);

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid            = ovalid_r;
  assign out_ch.duty_a           = oa_r;
  assign out_ch.duty_b           = ob_r;
  assign out_ch.duty_c           = oc_r;
  assign out_ch.position         = $signed(opos_r);
  assign out_ch.speed            = $signed(ospd_r);
  assign out_ch.tracking_updated = oupd_r;

  // state, configuration, datapath and output registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ovalid_r <= 1'b0;
      seen_r   <= 1'b0;
      prev_r   <= '0;
      turn_r   <= '0;
      sf_r     <= '0;
      lane_r   <= '0;
      cnt_r    <= '0;
      rev_r    <= 1'b0;
      pole_r   <= 7'd7;
      zo_r     <= '0;
      vlim_r   <= 16'd1024;
      vsup_r   <= 16'd3072;
      rate_r   <= 16'd1000;
      alpha_r  <= 16'd6554;
    end else begin
      // take register writes
      if (cfg_ch.valid) begin
        case (etsc_pkg::cfg_idx_t'(cfg_ch.index))
          etsc_pkg::REG_ENC_REVERSE: rev_r   <= cfg_ch.data[0];
          etsc_pkg::REG_POLE_PAIRS:  pole_r  <= cfg_ch.data[6:0];
          etsc_pkg::REG_ZERO_OFFSET: zo_r    <= cfg_ch.data[11:0];
          etsc_pkg::REG_VOLT_LIMIT:  vlim_r  <= cfg_ch.data;
          etsc_pkg::REG_SUPPLY:      vsup_r  <= cfg_ch.data;
          etsc_pkg::REG_SAMPLE_RATE: rate_r  <= cfg_ch.data;
          etsc_pkg::REG_VEL_ALPHA:   alpha_r <= cfg_ch.data;
          default: ;
        endcase
      end

      // drop the output word once taken, unless a new one replaces it
      if (ovalid_r && out_ch.ready && state_r != S_DONE) begin
        ovalid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            raw_r   <= AB'(in_ch.encoder_sample);
            ok_r    <= in_ch.sample_ok;
            tq_r    <= in_ch.torque_cmd;
            state_r <= S_TRACK;
          end
        end
        S_TRACK: begin
          if (ok_r) begin
            d_r     <= dwrap_w;
            prev_r  <= angle_w;
            turn_r  <= turn_eff + 32'(dwrap_w);
            seen_r  <= 1'b1;
            state_r <= S_DIFF;
          end else begin
            state_r <= S_ELEC;
          end
        end
        S_DIFF: begin
          ma_r    <= diff_w;
          mb_r    <= 32'(alpha_r);
          acc_r   <= '0;
          state_r <= S_VMUL;
        end
        S_ELEC: begin
          phase_r <= phase_w;
          numdm_r <= numdm_w;
          lane_r  <= '0;
          state_r <= S_SIN;
        end
        S_SIN: begin
          x_r     <= x_w;
          quad_r  <= p_w[AB-1:AB-2];
          ma_r    <= 64'(etsc_pkg::SIN_C);
          mb_r    <= x2_w;
          acc_r   <= '0;
          state_r <= S_M1;
        end
        S_VMUL, S_M1, S_M2, S_M3, S_M4: begin
          if (!mul_done) begin
            // advance the shift-add multiplier one bit
            if (mb_r[0]) begin
              acc_r <= acc_r + ma_r;
            end
            ma_r <= {ma_r[62:0], 1'b0};
            mb_r <= {1'b0, mb_r[31:1]};
          end else begin
            acc_r <= '0;
            case (state_r)
              S_VMUL: begin
                sf_r    <= sf_r + vshift_w[31:0];
                state_r <= S_ELEC;
              end
              S_M1: begin
                ma_r    <= 64'(t1_w);
                mb_r    <= x2_w;
                state_r <= S_M2;
              end
              S_M2: begin
                ma_r    <= 64'(t2_w);
                mb_r    <= 32'(x_r);
                state_r <= S_M3;
              end
              S_M3: begin
                neg_r   <= quad_r[1] && (mag_w != '0);
                ma_r    <= 64'(numdm_r);
                mb_r    <= mag_w;
                state_r <= S_M4;
              end
              default: begin
                rem_r   <= acc_r;
                dv_r    <= {18'b0, vsup_r, 30'b0} << (QB - 1);
                q_r     <= '0;
                cnt_r   <= '0;
                state_r <= S_DIV;
              end
            endcase
          end
        end
        S_DIV: begin
          // restoring division, one quotient bit a cycle
          if (div_ge) begin
            rem_r <= rem_r - dv_r;
          end
          q_r   <= q_fin;
          dv_r  <= {1'b0, dv_r[63:1]};
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == LAST_STEP) begin
            case (lane_r)
              2'd0:    da_r <= duty_w;
              2'd1:    db_r <= duty_w;
              default: dc_r <= duty_w;
            endcase
            if (lane_r == 2'd2) begin
              state_r <= S_DONE;
            end else begin
              lane_r  <= lane_r + 1'b1;
              state_r <= S_SIN;
            end
          end
        end
        S_DONE: begin
          // hold until the output register is free
          if (!ovalid_r || out_ch.ready) begin
            ovalid_r <= 1'b1;
            oa_r     <= da_r;
            ob_r     <= db_r;
            oc_r     <= dc_r;
            opos_r   <= turn_r;
            ospd_r   <= sf_r;
            oupd_r   <= ok_r;
            state_r  <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_lane_range: assert property (@(posedge clk) disable iff (!rst_n)
    lane_r != 2'd3) else $error("lane counter out of range");

  a_duty_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r |-> (oa_r != '0 && ob_r != '0 && oc_r != '0))
    else $error("duty below the smallest reachable value");

  a_done_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && ovalid_r && !out_ch.ready) |=> state_r == S_DONE)
    else $error("result left while output register was full");

  a_track_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TRACK && !ok_r) |=> $stable(turn_r) && $stable(sf_r))
    else $error("tracking changed on a failed sample");
`endif

endmodule

// ===== bench/encoder_tracked_sine_commutator_test.sv =====
// Self-checking bench for the encoder-tracked sine commutator: scoreboard plus drivers.
module encoder_tracked_sine_commutator_test;

  localparam int TURN        = 4096;
  localparam int QUARTER     = 1024;
  localparam int HALF        = 2048;
  localparam int DUTY_MID    = 128;
  localparam int STALL_LIMIT = 20000;
  localparam int SETTLE      = 400;
  localparam int LONG_HOLD   = 1500;
  localparam logic [etsc_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef struct {
    logic [7:0]  duty_a;
    logic [7:0]  duty_b;
    logic [7:0]  duty_c;
    logic [31:0] position;
    logic [31:0] speed;
    logic        updated;
  } drive_word_t;

  // Predicts commutation results and holds the ones still owed by the block
  class commutation_scoreboard;
    bit          reverse;
    int unsigned pole_pairs, zero_offset, volt_limit, supply, rate, alpha;
    logic [11:0] last_angle;
    logic [31:0] turns, speed_acc;
    bit          have_first;
    drive_word_t owed[$];
    int          errors;
    int          words_in, words_out, updates, clamps;

    function new();
      reverse = 0; pole_pairs = 7; zero_offset = 0; volt_limit = 1024;
      supply = 3072; rate = 1000; alpha = 6554;
      last_angle = 0; turns = 0; speed_acc = 0; have_first = 0;
      errors = 0; words_in = 0; words_out = 0; updates = 0; clamps = 0;
    endfunction

    function void write_reg(logic [etsc_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
      case (idx)
        etsc_pkg::REG_ENC_REVERSE: reverse = val[0];
        etsc_pkg::REG_POLE_PAIRS:  pole_pairs = val[6:0];
        etsc_pkg::REG_ZERO_OFFSET: zero_offset = val[11:0];
        etsc_pkg::REG_VOLT_LIMIT:  volt_limit = val;
        etsc_pkg::REG_SUPPLY:      supply = val;
        etsc_pkg::REG_SAMPLE_RATE: rate = val;
        etsc_pkg::REG_VEL_ALPHA:   alpha = val;
        default: ;
      endcase
    endfunction

    // Quarter-wave polynomial sine, Q2.30
    function longint sine_q30(logic [11:0] p);
      longint xs, x2, t, s;
      int x;
      x = p[10] ? QUARTER - p[9:0] : p[9:0];
      xs = longint'(x) <<< 20;
      x2 = (xs * xs) >>> 30;
      t = longint'(etsc_pkg::SIN_B) - ((x2 * longint'(etsc_pkg::SIN_C)) >>> 30);
      t = longint'(etsc_pkg::SIN_A) - ((x2 * t) >>> 30);
      s = (xs * t) >>> 30;
      if (s < 0) s = 0;
      if (s > longint'(etsc_pkg::ONE_Q30)) s = longint'(etsc_pkg::ONE_Q30);
      return p[11] ? -s : s;
    endfunction

    function logic [7:0] duty(logic [11:0] p, longint num);
      longint s, mag, term, d;
      s = sine_q30(p);
      mag = s < 0 ? -s : s;
      term = 0;
      if (supply != 0) term = ((DUTY_MID - 1) * num * mag) / (longint'(supply) <<< 30);
      d = s < 0 ? DUTY_MID - term : DUTY_MID + term;
      if (d < 0) d = 0;
      if (d > 2 * DUTY_MID - 1) d = 2 * DUTY_MID - 1;
      return d[7:0];
    endfunction

    // Advance tracking on an accepted word and queue its expected result
    function void note_sample(logic [11:0] raw, logic ok, logic signed [15:0] tq);
      logic [11:0] angle, e, ph;
      longint d, diff, v, num, lim;
      drive_word_t w;
      words_in++;
      if (ok) begin
        angle = reverse ? raw : 12'(TURN - raw);
        if (!have_first) begin
          last_angle = angle; turns = {20'd0, angle}; have_first = 1;
        end
        d = longint'(angle) - longint'(last_angle);
        if (d > HALF) d -= TURN;
        if (d < -HALF) d += TURN;
        last_angle = angle;
        turns += 32'(d);
        diff = d * longint'(rate) - longint'($signed(speed_acc));
        speed_acc += 32'((diff * longint'(alpha)) >>> 16);
        updates++;
      end
      v = tq;
      lim = longint'(volt_limit);
      if (v > lim || v < -lim) clamps++;
      if (v > lim) v = lim;
      if (v < -lim) v = -lim;
      e = 12'(32'(turns * pole_pairs) - zero_offset);
      ph = v >= 0 ? e + 12'(QUARTER) : e - 12'(QUARTER);
      num = 2 * (v < 0 ? -v : v);
      if (num > longint'(supply)) num = longint'(supply);
      w.duty_a = duty(ph, num);
      w.duty_b = duty(ph + 12'((TURN + 1) / 3), num);
      w.duty_c = duty(ph + 12'((2 * TURN + 1) / 3), num);
      w.position = turns;
      w.speed = speed_acc;
      w.updated = ok;
      owed.push_back(w);
    endfunction

    function void field(string name, longint e, longint a);
      if (e != a) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, e, a);
      end
    endfunction

    // Compare one result word with the oldest expectation
    function void check_word(drive_word_t a);
      drive_word_t e;
      words_out++;
      if (owed.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word, got position %0d", $time, $signed(a.position));
        return;
      end
      e = owed.pop_front();
      field("duty_a", e.duty_a, a.duty_a);
      field("duty_b", e.duty_b, a.duty_b);
      field("duty_c", e.duty_c, a.duty_c);
      field("position", $signed(e.position), $signed(a.position));
      field("speed", $signed(e.speed), $signed(a.speed));
      field("tracking_updated", e.updated, a.updated);
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  etsc_in_if  in_ch();
  etsc_out_if out_ch();
  etsc_cfg_if cfg_ch();

  encoder_tracked_sine_commutator dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  commutation_scoreboard sb = new();
  int src_idle_pct = 0;
  int snk_idle_pct = 0;
  bit hold_request = 0;
  int hold_left = 0;
  int stall_cycles = 0;
  logic [11:0] walk = 0;

  initial begin
    in_ch.valid = 0; in_ch.encoder_sample = 0; in_ch.sample_ok = 0; in_ch.torque_cmd = 0;
    cfg_ch.valid = 0; cfg_ch.index = 0; cfg_ch.data = 0;
    out_ch.ready = 0;
  end

  // Receiver: random back-pressure, with one long hold counted here
  always @(posedge clk) begin
    if (hold_request && hold_left == 0) begin
      hold_left = LONG_HOLD;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // Monitor both channels and feed the scoreboard
  always @(posedge clk) begin
    drive_word_t w;
    if (rst_n && in_ch.valid && in_ch.ready)
      sb.note_sample(in_ch.encoder_sample, in_ch.sample_ok, in_ch.torque_cmd);
    if (rst_n && out_ch.valid && out_ch.ready) begin
      w.duty_a = out_ch.duty_a; w.duty_b = out_ch.duty_b; w.duty_c = out_ch.duty_c;
      w.position = out_ch.position; w.speed = out_ch.speed;
      w.updated = out_ch.tracking_updated;
      sb.check_word(w);
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready) || !rst_n)
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("encoder_tracked_sine_commutator_test: done, errors");
      $finish;
    end
  end

  task automatic write_reg(logic [etsc_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.write_reg(idx, val);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Offer one word, with a random gap first when the sender idles
  task automatic send_word(logic [11:0] raw, logic ok, logic [15:0] tq);
    int gap;
    gap = 0;
    while ($urandom_range(99) < src_idle_pct) gap++;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.encoder_sample <= raw;
    in_ch.sample_ok <= ok;
    in_ch.torque_cmd <= tq;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Drop valid and wait until every word has come back
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_torque();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'($urandom_range(2048)) - 16'd1024;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_config();
    write_reg(etsc_pkg::REG_ENC_REVERSE, 16'($urandom_range(1)));
    write_reg(etsc_pkg::REG_POLE_PAIRS,
              $urandom_range(3) == 0 ? 16'd64 : 16'($urandom_range(1, 63)));
    write_reg(etsc_pkg::REG_ZERO_OFFSET, 16'($urandom_range(4095)));
    write_reg(etsc_pkg::REG_VOLT_LIMIT,
              $urandom_range(3) == 0 ? 16'hFFFF : 16'($urandom_range(6000)));
    write_reg(etsc_pkg::REG_SUPPLY,
              $urandom_range(5) == 0 ? 16'hFFFF : 16'($urandom_range(1, 8000)));
    write_reg(etsc_pkg::REG_SAMPLE_RATE, 16'($urandom_range(1, 65535)));
    write_reg(etsc_pkg::REG_VEL_ALPHA, 16'($urandom));
  endtask

  initial begin
    int phase;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: invalid before any sample, first sample, wraps and half-turn steps
    send_word(12'd100, 1'b0, 16'h0100);
    send_word(12'd0, 1'b1, 16'h0000);
    send_word(12'd4095, 1'b1, 16'h7FFF);
    send_word(12'd0, 1'b1, 16'h8000);
    send_word(12'd2048, 1'b1, 16'hFF00);
    send_word(12'd0, 1'b1, 16'h0600);
    send_word(12'd2047, 1'b1, 16'h0001);
    send_word(12'd4095, 1'b0, 16'hFFFF);
    send_word(12'd1234, 1'b1, 16'h0C00);
    drain();

    // Directed: extreme registers, then zero supply, poles, rate, alpha, limit, then ones
    write_reg(etsc_pkg::REG_ENC_REVERSE, 16'd1);
    write_reg(etsc_pkg::REG_POLE_PAIRS, 16'd64);
    write_reg(etsc_pkg::REG_ZERO_OFFSET, 16'd4095);
    write_reg(etsc_pkg::REG_VOLT_LIMIT, 16'hFFFF);
    write_reg(etsc_pkg::REG_SUPPLY, 16'hFFFF);
    write_reg(etsc_pkg::REG_SAMPLE_RATE, 16'hFFFF);
    write_reg(etsc_pkg::REG_VEL_ALPHA, 16'hFFFF);
    write_reg(REG_UNUSED, 16'h1234);
    send_word(12'd4095, 1'b1, 16'h7FFF);
    send_word(12'd2047, 1'b1, 16'h8000);
    send_word(12'd4095, 1'b1, 16'h4000);
    send_word(12'd10, 1'b1, 16'hC000);
    drain();
    write_reg(etsc_pkg::REG_SUPPLY, 16'd0);
    write_reg(etsc_pkg::REG_POLE_PAIRS, 16'd0);
    write_reg(etsc_pkg::REG_SAMPLE_RATE, 16'd0);
    write_reg(etsc_pkg::REG_VEL_ALPHA, 16'd0);
    write_reg(etsc_pkg::REG_VOLT_LIMIT, 16'd0);
    send_word(12'd500, 1'b1, 16'h7FFF);
    send_word(12'd900, 1'b1, 16'h8000);
    send_word(12'd900, 1'b0, 16'h0000);
    drain();
    write_reg(etsc_pkg::REG_SUPPLY, 16'd1);
    write_reg(etsc_pkg::REG_VOLT_LIMIT, 16'd1);
    write_reg(etsc_pkg::REG_POLE_PAIRS, 16'd1);
    send_word(12'd1, 1'b1, 16'h0001);
    send_word(12'd3000, 1'b1, 16'hFFFF);
    drain();

    // Random phases: mostly a smooth walk of the shaft, some jumps and dropouts
    for (phase = 0; phase < 8; phase++) begin
      random_config();
      if (phase < 3) begin
        src_idle_pct = 37; snk_idle_pct = 65;
      end else if (phase < 6) begin
        src_idle_pct = 65; snk_idle_pct = 37;
      end else begin
        src_idle_pct = 0; snk_idle_pct = 0;
      end
      if (phase == 6) hold_request = 1;
      walk = 12'($urandom);
      repeat (200) begin
        if ($urandom_range(9) == 0) walk = 12'($urandom);
        else walk = walk + 12'($urandom_range(400)) - 12'd200;
        send_word(walk, $urandom_range(9) != 0, pick_torque());
      end
      drain();
    end

    $display("Checked %0d words (%0d tracking updates, %0d clamped torques)",
             sb.words_out, sb.updates, sb.clamps);
    $display("over extreme and random register settings, with stalls on both sides.");
    if (sb.errors == 0 && sb.owed.size() == 0) begin
      $display("encoder_tracked_sine_commutator_test: done, clean");
    end else begin
      $display("encoder_tracked_sine_commutator_test: done, errors");
    end
    $finish;
  end
endmodule
